### src/srqc_pkg.sv
// ----------------------------------------------------------------------------
// srqc_pkg
// Shared types and constants of the read quality statistics core.
// ----------------------------------------------------------------------------
package srqc_pkg;

    // fixed widths and depths
    localparam int WIDE_W       = 48;
    localparam int TOTALS_DEPTH = 11;
    localparam int SCORE_W      = 7;
    localparam int FIFO_DEPTH   = 4;

    // base letter classes, codes of A to N equal the lane of the per-position row
    typedef enum logic [2:0] {
        LET_A     = 3'd0,
        LET_C     = 3'd1,
        LET_G     = 3'd2,
        LET_T     = 3'd3,
        LET_N     = 3'd4,
        LET_OTHER = 3'd5
    } letter_t;

    // read-out tables
    localparam logic [3:0] TBL_POS_A   = 4'd0;
    localparam logic [3:0] TBL_POS_C   = 4'd1;
    localparam logic [3:0] TBL_POS_G   = 4'd2;
    localparam logic [3:0] TBL_POS_T   = 4'd3;
    localparam logic [3:0] TBL_POS_N   = 4'd4;
    localparam logic [3:0] TBL_POS_QS  = 4'd5;
    localparam logic [3:0] TBL_BQ_HIST = 4'd6;
    localparam logic [3:0] TBL_MQ_HIST = 4'd7;
    localparam logic [3:0] TBL_GC_HIST = 4'd8;
    localparam logic [3:0] TBL_N_HIST  = 4'd9;
    localparam logic [3:0] TBL_LEN_HIST = 4'd10;
    localparam logic [3:0] TBL_TOTALS  = 4'd11;

    // run totals entries
    localparam int TOT_RAW_READS    = 0;
    localparam int TOT_RAW_BASES    = 1;
    localparam int TOT_PASSED_READS = 2;
    localparam int TOT_PASSED_QUALS = 3;
    localparam int TOT_GC_BASES     = 4;
    localparam int TOT_Q4           = 5;
    localparam int TOT_Q10          = 6;
    localparam int TOT_Q20          = 7;
    localparam int TOT_Q30          = 8;
    localparam int TOT_EXCESS_N     = 9;
    localparam int TOT_LOW_QUAL     = 10;

    // quality thresholds
    localparam logic [SCORE_W-1:0] Q_LEVEL_4  = 7'd4;
    localparam logic [SCORE_W-1:0] Q_LEVEL_10 = 7'd10;
    localparam logic [SCORE_W-1:0] Q_LEVEL_20 = 7'd20;
    localparam logic [SCORE_W-1:0] Q_LEVEL_30 = 7'd30;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_N_BASES    = 2'd0;
    localparam logic [1:0] CFG_LOW_QUAL_FRAC  = 2'd1;
    localparam logic [1:0] CFG_QUALITY_OFFSET = 2'd2;

    typedef struct packed {
        logic [8:0] max_n_bases;
        logic [8:0] low_qual_fraction;
        logic [6:0] quality_offset;
    } cfg_t;

    // classified item between front and back
    typedef struct packed {
        logic               req_type;
        letter_t            letter;
        logic [SCORE_W-1:0] score;
        logic               last_base;
        logic [3:0]         stat_table;
        logic [9:0]         stat_index;
    } item_t;

endpackage

### src/srqc_ifs.sv
// ----------------------------------------------------------------------------
// srqc_ifs
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface srqc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] base_letter;
    logic [7:0] quality_char;
    logic       last_base;
    logic [3:0] stat_table;
    logic [9:0] stat_index;

    modport source (
        output valid, req_type, base_letter, quality_char, last_base, stat_table,
               stat_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, base_letter, quality_char, last_base, stat_table,
               stat_index,
        output ready
    );
    // passive view for watching the channel
    modport monitor (
        input  valid, ready, req_type, base_letter, quality_char, last_base,
               stat_table, stat_index
    );
endinterface

interface srqc_out_if;
    logic        valid;
    logic        ready;
    logic        is_readout;
    logic        n_ok;
    logic        qual_ok;
    logic [9:0]  read_length;
    logic [9:0]  gc_count;
    logic [9:0]  n_count;
    logic [5:0]  mean_quality;
    logic        too_long;
    logic [47:0] stat_value;

    modport source (
        output valid, is_readout, n_ok, qual_ok, read_length, gc_count, n_count,
               mean_quality, too_long, stat_value,
        input  ready
    );
    modport sink (
        input  valid, is_readout, n_ok, qual_ok, read_length, gc_count, n_count,
               mean_quality, too_long, stat_value,
        output ready
    );
    // passive view for watching the channel
    modport monitor (
        input  valid, ready, is_readout, n_ok, qual_ok, read_length, gc_count,
               n_count, mean_quality, too_long, stat_value
    );
endinterface

### src/srqc_front.sv
// ----------------------------------------------------------------------------
// srqc_front
// Accepts items, classifies the base letter and computes the clamped score.
// ----------------------------------------------------------------------------
module srqc_front
    import srqc_pkg::*;
#(
    parameter int QUAL_LEVELS = 64
)
(
    srqc_in_if.sink in_ch,
    input  cfg_t    cfg,
    input  logic    fifo_full,
    input  logic    clearing,
    output logic    push,
    output item_t   push_item
);

    logic [7:0] raw_q;
    logic [7:0] clamp_q;

    // accept while the queue has room and the stores are not being cleared
    assign in_ch.ready = ~fifo_full & ~clearing;
    assign push        = in_ch.valid & in_ch.ready;

    // quality score, clamped to the histogram range
    always_comb
    begin
        raw_q = (in_ch.quality_char >= {1'b0, cfg.quality_offset})
              ? in_ch.quality_char - {1'b0, cfg.quality_offset} : 8'd0;
        clamp_q = (raw_q > 8'(QUAL_LEVELS - 1)) ? 8'(QUAL_LEVELS - 1) : raw_q;
    end

    // letter class and item fields
    always_comb
    begin
        push_item.req_type   = in_ch.req_type;
        push_item.score      = clamp_q[SCORE_W-1:0];
        push_item.last_base  = in_ch.last_base;
        push_item.stat_table = in_ch.stat_table;
        push_item.stat_index = in_ch.stat_index;
        case (in_ch.base_letter)
            8'h41:   push_item.letter = LET_A;
            8'h43:   push_item.letter = LET_C;
            8'h47:   push_item.letter = LET_G;
            8'h54:   push_item.letter = LET_T;
            8'h4E:   push_item.letter = LET_N;
            default: push_item.letter = LET_OTHER;
        endcase
    end

endmodule

### src/srqc_fifo.sv
// ----------------------------------------------------------------------------
// srqc_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module srqc_fifo
    import srqc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  head_valid,
    output logic  full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    item_t              slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (PTR_W+1)'(FIFO_DEPTH));

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### src/srqc_back.sv
// ----------------------------------------------------------------------------
// srqc_back
// Statistics stores, per-read accumulation, mean divider and result register.
// ----------------------------------------------------------------------------
module srqc_back
    import srqc_pkg::*;
#(
    parameter int MAX_READ_LEN = 512,
    parameter int QUAL_LEVELS  = 64,
    parameter int COUNT_WIDTH  = 40
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t head,
    input  logic  head_valid,
    output logic  pop,
    input  cfg_t  cfg,
    output logic  clearing,
    srqc_out_if.source out_ch
);

    localparam int CW      = COUNT_WIDTH;
    localparam int PW      = $clog2(MAX_READ_LEN);
    localparam int HW      = $clog2(MAX_READ_LEN + 1);
    localparam int LW      = HW;
    localparam int QW      = $clog2(QUAL_LEVELS);
    localparam int SW      = $clog2(MAX_READ_LEN * (QUAL_LEVELS - 1) + 1);
    localparam int DCW     = $clog2(SW);
    localparam int ROWW    = 5 * CW + WIDE_W;
    localparam int CLR_LEN = (MAX_READ_LEN + 1 > QUAL_LEVELS) ? MAX_READ_LEN + 1
                                                             : QUAL_LEVELS;
    localparam int CLRW    = $clog2(CLR_LEN);
    localparam int IW      = (HW > 10) ? HW : 10;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_BASE   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_FIN_RD = 7'b0010000,
        S_FIN_WR = 7'b0100000,
        S_RO     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    item_t  it_reg;

    logic [CLRW-1:0] clr_reg;
    logic [LW-1:0]   cur_pos_reg;
    logic [LW-1:0]   cur_gc_reg;
    logic [LW-1:0]   cur_n_reg;
    logic [LW-1:0]   cur_low_reg;
    logic [SW-1:0]   cur_sum_reg;
    logic            cur_ovf_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic [LW-1:0]   rem_reg;
    logic [SW-1:0]   quo_reg;
    logic [WIDE_W-1:0] totals_reg [TOTALS_DEPTH];

    // stores
    logic [ROWW-1:0]   pos_mem [MAX_READ_LEN];
    logic [WIDE_W-1:0] bqh_mem [QUAL_LEVELS];
    logic [CW-1:0]     mqh_mem [QUAL_LEVELS];
    logic [CW-1:0]     gch_mem [MAX_READ_LEN + 1];
    logic [CW-1:0]     nch_mem [MAX_READ_LEN + 1];
    logic [CW-1:0]     lnh_mem [MAX_READ_LEN + 1];

    logic [ROWW-1:0]   pos_rd, pos_wd;
    logic [WIDE_W-1:0] bqh_rd, bqh_wd;
    logic [CW-1:0]     mqh_rd, mqh_wd, gch_rd, gch_wd, nch_rd, nch_wd, lnh_rd, lnh_wd;
    logic [PW-1:0]     pos_ra, pos_wa;
    logic [QW-1:0]     bqh_ra, bqh_wa, mqh_ra, mqh_wa;
    logic [HW-1:0]     gch_ra, gch_wa, nch_ra, nch_wa, lnh_ra, lnh_wa;
    logic              pos_we, bqh_we, mqh_we, gch_we, nch_we, lnh_we;

    logic [IW-1:0]     head_idx;
    logic              wants_out;
    logic              take;
    logic              overflowed;
    logic [QW-1:0]     mean_w;
    logic [6:0]        mean7;
    logic [LW:0]       rem_sh;
    logic              quo_bit;
    logic              n_ok_w;
    logic              q_ok_w;
    logic [LW+8:0]     low_scaled;
    logic [LW+8:0]     frac_len;
    logic [WIDE_W-1:0] ro_val;
    logic [CW-1:0]     lane;
    logic [WIDE_W:0]   qs_sum;

    logic              out_valid_reg;
    logic              o_n_ok_reg, o_q_ok_reg, o_ro_reg, o_long_reg;
    logic [9:0]        o_len_reg, o_gc_reg, o_n_reg;
    logic [5:0]        o_mean_reg;
    logic [WIDE_W-1:0] o_val_reg;

    function automatic logic [CW-1:0] sat_inc_c(input logic [CW-1:0] x);
        sat_inc_c = (x == {CW{1'b1}}) ? x : x + 1'b1;
    endfunction

    function automatic logic [WIDE_W-1:0] sat_add_w(input logic [WIDE_W-1:0] x,
                                                    input logic [WIDE_W-1:0] v);
        logic [WIDE_W:0] s;
        s = {1'b0, x} + {1'b0, v};
        sat_add_w = s[WIDE_W] ? {WIDE_W{1'b1}} : s[WIDE_W-1:0];
    endfunction

    assign clearing  = (state_reg == S_CLEAR);
    assign head_idx  = IW'(head.stat_index);
    assign wants_out = head.req_type | head.last_base;
    assign take      = (state_reg == S_IDLE) & head_valid & (~wants_out | ~out_valid_reg);
    assign pop       = take;
    assign overflowed = (cur_pos_reg >= LW'(MAX_READ_LEN));

    // mean quality, clamped to the histogram range
    always_comb
    begin
        if (cur_pos_reg == '0)
            mean_w = '0;
        else if (quo_reg > SW'(QUAL_LEVELS - 1))
            mean_w = QW'(QUAL_LEVELS - 1);
        else
            mean_w = quo_reg[QW-1:0];
        mean7 = 7'(mean_w);
    end

    // one restoring division step per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, cur_sum_reg[DCW'(SW - 1) - div_cnt_reg]};
        quo_bit = (rem_sh >= {1'b0, cur_pos_reg});
    end

    // read verdict
    always_comb
    begin
        n_ok_w     = ({1'b0, cur_n_reg} <= (LW+1)'(cfg.max_n_bases));
        low_scaled = {1'b0, cur_low_reg, 8'd0};
        frac_len   = (LW+9)'(cfg.low_qual_fraction * cur_pos_reg);
        q_ok_w     = ~(low_scaled > frac_len);
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLRW'(CLR_LEN - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (take)
                begin
                    if (head.req_type)
                        state_next = S_RO;
                    else if (!overflowed)
                        state_next = S_BASE;
                    else if (head.last_base)
                        state_next = S_DIV;
                end
            end
            S_BASE:
            begin
                state_next = it_reg.last_base ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DCW'(SW - 1))
                    state_next = S_FIN_RD;
            end
            S_FIN_RD: state_next = S_FIN_WR;
            S_FIN_WR: state_next = S_IDLE;
            S_RO:     state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    // store read addresses
    always_comb
    begin
        pos_ra = head.req_type ? head_idx[PW-1:0] : cur_pos_reg[PW-1:0];
        bqh_ra = head.req_type ? head_idx[QW-1:0] : head.score[QW-1:0];
        if (state_reg == S_FIN_RD)
        begin
            mqh_ra = mean_w;
            gch_ra = HW'(cur_gc_reg);
            nch_ra = HW'(cur_n_reg);
            lnh_ra = HW'(cur_pos_reg);
        end
        else
        begin
            mqh_ra = head_idx[QW-1:0];
            gch_ra = head_idx[HW-1:0];
            nch_ra = head_idx[HW-1:0];
            lnh_ra = head_idx[HW-1:0];
        end
    end

    // store writes: clearing pass, base update, read-end update
    always_comb
    begin
        pos_we = 1'b0;
        bqh_we = 1'b0;
        mqh_we = 1'b0;
        gch_we = 1'b0;
        nch_we = 1'b0;
        lnh_we = 1'b0;
        pos_wa = cur_pos_reg[PW-1:0];
        bqh_wa = it_reg.score[QW-1:0];
        mqh_wa = mean_w;
        gch_wa = HW'(cur_gc_reg);
        nch_wa = HW'(cur_n_reg);
        lnh_wa = HW'(cur_pos_reg);
        pos_wd = pos_rd;
        bqh_wd = sat_add_w(bqh_rd, WIDE_W'(1));
        mqh_wd = sat_inc_c(mqh_rd);
        gch_wd = sat_inc_c(gch_rd);
        nch_wd = sat_inc_c(nch_rd);
        lnh_wd = sat_inc_c(lnh_rd);
        lane   = '0;
        qs_sum = '0;
        if (state_reg == S_CLEAR)
        begin
            pos_we = (int'(clr_reg) < MAX_READ_LEN);
            bqh_we = (int'(clr_reg) < QUAL_LEVELS);
            mqh_we = (int'(clr_reg) < QUAL_LEVELS);
            gch_we = (int'(clr_reg) <= MAX_READ_LEN);
            nch_we = gch_we;
            lnh_we = gch_we;
            pos_wa = clr_reg[PW-1:0];
            bqh_wa = clr_reg[QW-1:0];
            mqh_wa = clr_reg[QW-1:0];
            gch_wa = clr_reg[HW-1:0];
            nch_wa = clr_reg[HW-1:0];
            lnh_wa = clr_reg[HW-1:0];
            pos_wd = '0;
            bqh_wd = '0;
            mqh_wd = '0;
            gch_wd = '0;
            nch_wd = '0;
            lnh_wd = '0;
        end
        else if (state_reg == S_BASE)
        begin
            pos_we = 1'b1;
            bqh_we = 1'b1;
            for (int k = 0; k < 5; k++)
            begin
                lane = pos_rd[k*CW +: CW];
                if (3'(k) == it_reg.letter)
                    pos_wd[k*CW +: CW] = sat_inc_c(lane);
            end
            qs_sum = {1'b0, pos_rd[5*CW +: WIDE_W]} + (WIDE_W+1)'(it_reg.score);
            pos_wd[5*CW +: WIDE_W] = qs_sum[WIDE_W] ? {WIDE_W{1'b1}}
                                                    : qs_sum[WIDE_W-1:0];
        end
        else if (state_reg == S_FIN_WR)
        begin
            mqh_we = 1'b1;
            gch_we = 1'b1;
            nch_we = 1'b1;
            lnh_we = 1'b1;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        pos_rd <= pos_mem[pos_ra];
        if (bqh_we)
            bqh_mem[bqh_wa] <= bqh_wd;
        bqh_rd <= bqh_mem[bqh_ra];
        if (mqh_we)
            mqh_mem[mqh_wa] <= mqh_wd;
        mqh_rd <= mqh_mem[mqh_ra];
        if (gch_we)
            gch_mem[gch_wa] <= gch_wd;
        gch_rd <= gch_mem[gch_ra];
        if (nch_we)
            nch_mem[nch_wa] <= nch_wd;
        nch_rd <= nch_mem[nch_ra];
        if (lnh_we)
            lnh_mem[lnh_wa] <= lnh_wd;
        lnh_rd <= lnh_mem[lnh_ra];
    end

    // read-out value select
    always_comb
    begin
        ro_val = '0;
        case (it_reg.stat_table) inside
            [TBL_POS_A:TBL_POS_N]:
                if (int'(it_reg.stat_index) < MAX_READ_LEN)
                    ro_val = WIDE_W'(pos_rd[int'(it_reg.stat_table) * CW +: CW]);
            TBL_POS_QS:
                if (int'(it_reg.stat_index) < MAX_READ_LEN)
                    ro_val = pos_rd[5*CW +: WIDE_W];
            TBL_BQ_HIST:
                if (int'(it_reg.stat_index) < QUAL_LEVELS)
                    ro_val = bqh_rd;
            TBL_MQ_HIST:
                if (int'(it_reg.stat_index) < QUAL_LEVELS)
                    ro_val = WIDE_W'(mqh_rd);
            TBL_GC_HIST:
                if (int'(it_reg.stat_index) <= MAX_READ_LEN)
                    ro_val = WIDE_W'(gch_rd);
            TBL_N_HIST:
                if (int'(it_reg.stat_index) <= MAX_READ_LEN)
                    ro_val = WIDE_W'(nch_rd);
            TBL_LEN_HIST:
                if (int'(it_reg.stat_index) <= MAX_READ_LEN)
                    ro_val = WIDE_W'(lnh_rd);
            TBL_TOTALS:
                if (int'(it_reg.stat_index) < TOTALS_DEPTH)
                    ro_val = totals_reg[it_reg.stat_index[3:0]];
            default: ro_val = '0;
        endcase
    end

    // control, per-read accumulation, totals and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cur_pos_reg   <= '0;
            cur_gc_reg    <= '0;
            cur_n_reg     <= '0;
            cur_low_reg   <= '0;
            cur_sum_reg   <= '0;
            cur_ovf_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOTALS_DEPTH; i++)
                totals_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                    clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                    if (take && !head.req_type && overflowed)
                        cur_ovf_reg <= 1'b1;
                S_BASE:
                begin
                    cur_pos_reg <= cur_pos_reg + 1'b1;
                    cur_sum_reg <= cur_sum_reg + SW'(it_reg.score);
                    if (it_reg.letter == LET_G || it_reg.letter == LET_C)
                        cur_gc_reg <= cur_gc_reg + 1'b1;
                    if (it_reg.letter == LET_N)
                        cur_n_reg <= cur_n_reg + 1'b1;
                    if (it_reg.score < Q_LEVEL_20)
                        cur_low_reg <= cur_low_reg + 1'b1;
                    if (it_reg.score >= Q_LEVEL_30)
                        totals_reg[TOT_Q30] <= sat_add_w(totals_reg[TOT_Q30], WIDE_W'(1));
                    if (it_reg.score >= Q_LEVEL_20)
                        totals_reg[TOT_Q20] <= sat_add_w(totals_reg[TOT_Q20], WIDE_W'(1));
                    if (it_reg.score >= Q_LEVEL_10)
                        totals_reg[TOT_Q10] <= sat_add_w(totals_reg[TOT_Q10], WIDE_W'(1));
                    if (it_reg.score >= Q_LEVEL_4)
                        totals_reg[TOT_Q4] <= sat_add_w(totals_reg[TOT_Q4], WIDE_W'(1));
                end
                S_DIV:
                begin
                    div_cnt_reg <= (div_cnt_reg == DCW'(SW - 1)) ? '0
                                                                 : div_cnt_reg + 1'b1;
                    rem_reg <= quo_bit ? LW'(rem_sh - {1'b0, cur_pos_reg})
                                       : rem_sh[LW-1:0];
                end
                S_FIN_WR:
                begin
                    totals_reg[TOT_RAW_READS] <=
                        sat_add_w(totals_reg[TOT_RAW_READS], WIDE_W'(1));
                    totals_reg[TOT_RAW_BASES] <=
                        sat_add_w(totals_reg[TOT_RAW_BASES], WIDE_W'(cur_pos_reg));
                    totals_reg[TOT_GC_BASES] <=
                        sat_add_w(totals_reg[TOT_GC_BASES], WIDE_W'(cur_gc_reg));
                    if (n_ok_w)
                        totals_reg[TOT_PASSED_READS] <=
                            sat_add_w(totals_reg[TOT_PASSED_READS], WIDE_W'(1));
                    else
                        totals_reg[TOT_EXCESS_N] <=
                            sat_add_w(totals_reg[TOT_EXCESS_N], WIDE_W'(1));
                    if (q_ok_w)
                        totals_reg[TOT_PASSED_QUALS] <=
                            sat_add_w(totals_reg[TOT_PASSED_QUALS], WIDE_W'(1));
                    else
                        totals_reg[TOT_LOW_QUAL] <=
                            sat_add_w(totals_reg[TOT_LOW_QUAL], WIDE_W'(1));
                    cur_pos_reg   <= '0;
                    cur_gc_reg    <= '0;
                    cur_n_reg     <= '0;
                    cur_low_reg   <= '0;
                    cur_sum_reg   <= '0;
                    cur_ovf_reg   <= 1'b0;
                    rem_reg       <= '0;
                    out_valid_reg <= 1'b1;
                end
                S_RO:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // latched item, quotient and result payload
    always_ff @(posedge clk)
    begin
        if (take)
            it_reg <= head;
        if (state_reg == S_DIV)
            quo_reg <= {quo_reg[SW-2:0], quo_bit};
        if (state_reg == S_FIN_WR)
        begin
            o_ro_reg   <= 1'b0;
            o_n_ok_reg <= n_ok_w;
            o_q_ok_reg <= q_ok_w;
            o_len_reg  <= 10'(cur_pos_reg);
            o_gc_reg   <= 10'(cur_gc_reg);
            o_n_reg    <= 10'(cur_n_reg);
            o_mean_reg <= (mean7 > 7'd63) ? 6'd63 : mean7[5:0];
            o_long_reg <= cur_ovf_reg;
            o_val_reg  <= '0;
        end
        else if (state_reg == S_RO)
        begin
            o_ro_reg   <= 1'b1;
            o_n_ok_reg <= 1'b0;
            o_q_ok_reg <= 1'b0;
            o_len_reg  <= '0;
            o_gc_reg   <= '0;
            o_n_reg    <= '0;
            o_mean_reg <= '0;
            o_long_reg <= 1'b0;
            o_val_reg  <= ro_val;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.is_readout   = o_ro_reg;
    assign out_ch.n_ok         = o_n_ok_reg;
    assign out_ch.qual_ok      = o_q_ok_reg;
    assign out_ch.read_length  = o_len_reg;
    assign out_ch.gc_count     = o_gc_reg;
    assign out_ch.n_count      = o_n_reg;
    assign out_ch.mean_quality = o_mean_reg;
    assign out_ch.too_long     = o_long_reg;
    assign out_ch.stat_value   = o_val_reg;

endmodule

### src/sequence_read_qc_statistics_core.sv
// ----------------------------------------------------------------------------
// sequence_read_qc_statistics_core
// Read quality statistics: front classifier, item queue and statistics back end.
// ----------------------------------------------------------------------------
// In the back end a base is read from the stores when it is taken and written back in
// S_BASE. A read end adds a 15-step mean divider plus a histogram read and write; a
// read-out reads the stores when taken and registers the value in S_RO.
// After reset a clearing pass zeroes every store; no item is accepted during it,
// configuration writes are taken.
module sequence_read_qc_statistics_core
    import srqc_pkg::*;
#(
    parameter int MAX_READ_LEN = 512,
    parameter int QUAL_LEVELS  = 64,
    parameter int COUNT_WIDTH  = 40
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    srqc_in_if.sink    in_ch,
    srqc_out_if.source out_ch
);

    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    logic  pop;
    item_t head;
    logic  head_valid;
    logic  fifo_full;
    logic  clearing;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_n_bases       <= 9'd3;
            cfg_reg.low_qual_fraction <= 9'd128;
            cfg_reg.quality_offset    <= 7'd33;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_N_BASES:    cfg_reg.max_n_bases       <= cfg_data;
                CFG_LOW_QUAL_FRAC:  cfg_reg.low_qual_fraction <= cfg_data;
                CFG_QUALITY_OFFSET: cfg_reg.quality_offset    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    srqc_front #(
        .QUAL_LEVELS (QUAL_LEVELS)
    ) u_front (
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item)
    );

    srqc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (fifo_full)
    );

    srqc_back #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .QUAL_LEVELS  (QUAL_LEVELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .out_ch     (out_ch)
    );

endmodule

### dv/srqc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqc_checker
// Watches the item and result channels of the read quality statistics core,
// keeps its own copy of every statistics store and compares each result.
// ----------------------------------------------------------------------------
module srqc_checker
    import srqc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    srqc_in_if.monitor  in_mon,
    srqc_out_if.monitor out_mon,
    output int          error_count,
    output int          pending_count
);
    localparam int MAX_LEN = 512;
    localparam int LEVELS  = 64;
    localparam int CNT_W   = 40;

    typedef struct packed {
        logic        is_readout;
        logic        n_ok;
        logic        qual_ok;
        logic [9:0]  read_length;
        logic [9:0]  gc_count;
        logic [9:0]  n_count;
        logic [5:0]  mean_quality;
        logic        too_long;
        logic [47:0] stat_value;
    } verdict_t;

    logic [47:0] pos_cnt [5][MAX_LEN];
    logic [47:0] pos_qsum [MAX_LEN];
    logic [47:0] bq_hist [LEVELS];
    logic [47:0] mq_hist [LEVELS];
    logic [47:0] gc_hist [MAX_LEN+1];
    logic [47:0] nc_hist [MAX_LEN+1];
    logic [47:0] len_hist [MAX_LEN+1];
    logic [47:0] totals [TOTALS_DEPTH];
    int unsigned rd_pos, rd_gc, rd_n, rd_qsum, rd_low;
    bit          rd_over;
    int unsigned lim_n, lim_frac, q_off;

    verdict_t expected_q[$];

    // saturating increment at a given width
    function automatic logic [47:0] sat_inc(logic [47:0] v, longint unsigned d, int w);
        longint unsigned top;
        top = (64'd1 << w) - 1;
        if (v > top || d > top - v)
            return top[47:0];
        return 48'(v + d);
    endfunction

    function automatic logic [47:0] stat_lookup(logic [3:0] t, logic [9:0] i);
        case (t)
            TBL_POS_A, TBL_POS_C, TBL_POS_G, TBL_POS_T, TBL_POS_N:
                return i < MAX_LEN ? pos_cnt[t][i] : '0;
            TBL_POS_QS:   return i < MAX_LEN ? pos_qsum[i] : '0;
            TBL_BQ_HIST:  return i < LEVELS ? bq_hist[i] : '0;
            TBL_MQ_HIST:  return i < LEVELS ? mq_hist[i] : '0;
            TBL_GC_HIST:  return i <= MAX_LEN ? gc_hist[i] : '0;
            TBL_N_HIST:   return i <= MAX_LEN ? nc_hist[i] : '0;
            TBL_LEN_HIST: return i <= MAX_LEN ? len_hist[i] : '0;
            TBL_TOTALS:   return i < TOTALS_DEPTH ? totals[i] : '0;
            default:      return '0;
        endcase
    endfunction

    // one base of the current read
    task automatic tally_base(logic [7:0] letter, logic [7:0] qchar);
        int unsigned q;
        int lane;
        if (rd_pos >= MAX_LEN)
        begin
            rd_over = 1;
            return;
        end
        lane = -1;
        case (letter)
            "A": lane = LET_A;
            "C": lane = LET_C;
            "G": lane = LET_G;
            "T": lane = LET_T;
            "N": lane = LET_N;
            default: lane = -1;
        endcase
        if (lane >= 0)
            pos_cnt[lane][rd_pos] = sat_inc(pos_cnt[lane][rd_pos], 1, CNT_W);
        if (letter == "G" || letter == "C")
            rd_gc++;
        if (letter == "N")
            rd_n++;
        q = qchar >= q_off ? qchar - q_off : 0;
        if (q > LEVELS - 1)
            q = LEVELS - 1;
        pos_qsum[rd_pos] = sat_inc(pos_qsum[rd_pos], q, 48);
        bq_hist[q] = sat_inc(bq_hist[q], 1, 48);
        rd_qsum += q;
        if (q >= Q_LEVEL_30) totals[TOT_Q30] = sat_inc(totals[TOT_Q30], 1, 48);
        if (q >= Q_LEVEL_20) totals[TOT_Q20] = sat_inc(totals[TOT_Q20], 1, 48);
        if (q >= Q_LEVEL_10) totals[TOT_Q10] = sat_inc(totals[TOT_Q10], 1, 48);
        if (q >= Q_LEVEL_4)  totals[TOT_Q4]  = sat_inc(totals[TOT_Q4], 1, 48);
        if (q < Q_LEVEL_20)
            rd_low++;
        rd_pos++;
    endtask

    // end of read: histograms, totals and the verdict
    task automatic close_read();
        verdict_t v;
        int unsigned mean;
        bit nok, qok;
        mean = rd_pos ? rd_qsum / rd_pos : 0;
        if (mean > LEVELS - 1)
            mean = LEVELS - 1;
        nok = rd_n <= lim_n;
        qok = !(longint'(rd_low) * 256 > longint'(lim_frac) * rd_pos);
        mq_hist[mean] = sat_inc(mq_hist[mean], 1, CNT_W);
        gc_hist[rd_gc] = sat_inc(gc_hist[rd_gc], 1, CNT_W);
        nc_hist[rd_n] = sat_inc(nc_hist[rd_n], 1, CNT_W);
        len_hist[rd_pos] = sat_inc(len_hist[rd_pos], 1, CNT_W);
        totals[TOT_RAW_READS] = sat_inc(totals[TOT_RAW_READS], 1, 48);
        totals[TOT_RAW_BASES] = sat_inc(totals[TOT_RAW_BASES], rd_pos, 48);
        totals[TOT_GC_BASES] = sat_inc(totals[TOT_GC_BASES], rd_gc, 48);
        if (nok)
            totals[TOT_PASSED_READS] = sat_inc(totals[TOT_PASSED_READS], 1, 48);
        else
            totals[TOT_EXCESS_N] = sat_inc(totals[TOT_EXCESS_N], 1, 48);
        if (qok)
            totals[TOT_PASSED_QUALS] = sat_inc(totals[TOT_PASSED_QUALS], 1, 48);
        else
            totals[TOT_LOW_QUAL] = sat_inc(totals[TOT_LOW_QUAL], 1, 48);
        v = '0;
        v.n_ok = nok;
        v.qual_ok = qok;
        v.read_length = rd_pos[9:0];
        v.gc_count = rd_gc[9:0];
        v.n_count = rd_n[9:0];
        v.mean_quality = mean[5:0];
        v.too_long = rd_over;
        expected_q = {expected_q, v};
        rd_pos = 0; rd_gc = 0; rd_n = 0; rd_qsum = 0; rd_low = 0; rd_over = 0;
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        error_count++;
        $display("checker: %s got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // predict and compare on every edge
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        verdict_t w;
        if (!rst_n)
        begin
            foreach (pos_cnt[l, i]) pos_cnt[l][i] = '0;
            foreach (pos_qsum[i]) pos_qsum[i] = '0;
            foreach (bq_hist[i]) bq_hist[i] = '0;
            foreach (mq_hist[i]) mq_hist[i] = '0;
            foreach (gc_hist[i]) begin gc_hist[i] = '0; nc_hist[i] = '0; len_hist[i] = '0; end
            foreach (totals[i]) totals[i] = '0;
            rd_pos = 0; rd_gc = 0; rd_n = 0; rd_qsum = 0; rd_low = 0; rd_over = 0;
            lim_n = 3; lim_frac = 128; q_off = 33;
            expected_q.delete();
            error_count = 0;
        end
        else
        begin
            // result side first: a result never answers an item of this edge
            if (out_mon.valid && out_mon.ready)
            begin
                v = {out_mon.is_readout, out_mon.n_ok, out_mon.qual_ok, out_mon.read_length,
                     out_mon.gc_count, out_mon.n_count, out_mon.mean_quality,
                     out_mon.too_long, out_mon.stat_value};
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result, is_readout", v.is_readout, 0);
                else
                begin
                    w = expected_q.pop_front();
                    if (v.is_readout !== w.is_readout)
                        report_mismatch("is_readout", v.is_readout, w.is_readout);
                    if (v.n_ok !== w.n_ok) report_mismatch("n_ok", v.n_ok, w.n_ok);
                    if (v.qual_ok !== w.qual_ok)
                        report_mismatch("qual_ok", v.qual_ok, w.qual_ok);
                    if (v.read_length !== w.read_length)
                        report_mismatch("read_length", v.read_length, w.read_length);
                    if (v.gc_count !== w.gc_count)
                        report_mismatch("gc_count", v.gc_count, w.gc_count);
                    if (v.n_count !== w.n_count)
                        report_mismatch("n_count", v.n_count, w.n_count);
                    if (v.mean_quality !== w.mean_quality)
                        report_mismatch("mean_quality", v.mean_quality, w.mean_quality);
                    if (v.too_long !== w.too_long)
                        report_mismatch("too_long", v.too_long, w.too_long);
                    if (v.stat_value !== w.stat_value)
                        report_mismatch("stat_value", v.stat_value, w.stat_value);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_N_BASES:    lim_n = cfg_data;
                    CFG_LOW_QUAL_FRAC:  lim_frac = cfg_data;
                    CFG_QUALITY_OFFSET: q_off = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.req_type)
                begin
                    w = '0;
                    w.is_readout = 1;
                    w.stat_value = stat_lookup(in_mon.stat_table, in_mon.stat_index);
                    expected_q = {expected_q, w};
                end
                else
                begin
                    tally_base(in_mon.base_letter, in_mon.quality_char);
                    if (in_mon.last_base)
                        close_read();
                end
            end
        end
        pending_count = expected_q.size();
    end
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Read quality statistics test: directed reads and read-outs, then random reads
// and read-outs under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import srqc_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;
    int         error_count;
    int         pending_count;
    int         quiet_cycles;
    bit         calm;

    srqc_in_if  in_ch ();
    srqc_out_if out_ch ();

    sequence_read_qc_statistics_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    srqc_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mon        (in_ch.monitor),
        .out_mon       (out_ch.monitor),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        int gap;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 0;
                gap = $urandom_range(1, 7);
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ch.ready <= 1;
        end
    end

    task automatic send_item(bit rq, logic [7:0] letter, logic [7:0] qc, bit last,
                             logic [3:0] tbl, logic [9:0] idx);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1;
        in_ch.req_type     <= rq;
        in_ch.base_letter  <= letter;
        in_ch.quality_char <= qc;
        in_ch.last_base    <= last;
        in_ch.stat_table   <= tbl;
        in_ch.stat_index   <= idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_base(logic [7:0] letter, logic [7:0] qc, bit last);
        send_item(0, letter, qc, last, 4'($urandom), 10'($urandom));
    endtask

    task automatic send_readout(logic [3:0] tbl, logic [9:0] idx);
        send_item(1, 8'($urandom), 8'($urandom), 1'($urandom), tbl, idx);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 6))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "N";
            5: return 8'($urandom);
            default: return "G";
        endcase
    endfunction

    // drain and settle before a register write
    task automatic quiesce();
        in_ch.valid <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic random_read(int len);
        for (int i = 0; i < len; i++)
            send_base(pick_letter(),
                      ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(30, 110)),
                      i == len - 1);
    endtask

    task automatic random_readout();
        logic [3:0] t;
        logic [9:0] i;
        t = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0: i = 10'($urandom);
            1: i = 10'($urandom_range(0, 12));
            2: i = 10'($urandom_range(500, 520));
            default: i = 10'($urandom_range(0, 70));
        endcase
        send_readout(t, i);
    endtask

    initial
    begin
        int sent;
        calm         = 0;
        rst_n        = 0;
        cfg_we       = 0;
        cfg_index    = CFG_MAX_N_BASES;
        cfg_data     = 0;
        in_ch.valid  = 0;
        in_ch.req_type = 0;
        in_ch.base_letter = 0;
        in_ch.quality_char = 0;
        in_ch.last_base = 0;
        in_ch.stat_table = 0;
        in_ch.stat_index = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every letter, quality extremes, an empty-ish one-base read
        send_base("A", 8'd0, 0);
        send_base("C", 8'd255, 0);
        send_base("G", 8'd33, 0);
        send_base("T", 8'd63, 0);
        send_base("N", 8'd53, 0);
        send_base("x", 8'd43, 1);
        send_base("N", 8'd37, 1);
        send_readout(TBL_POS_A, 0);
        send_readout(TBL_POS_C, 1);
        send_readout(TBL_POS_G, 2);
        send_readout(TBL_POS_T, 3);
        send_readout(TBL_POS_N, 0);
        send_readout(TBL_POS_QS, 0);
        send_readout(TBL_BQ_HIST, 63);
        send_readout(TBL_MQ_HIST, 0);
        send_readout(TBL_GC_HIST, 2);
        send_readout(TBL_N_HIST, 1);
        send_readout(TBL_LEN_HIST, 6);
        send_readout(TBL_TOTALS, 10'(TOT_LOW_QUAL));
        send_readout(TBL_TOTALS, 11);
        send_readout(4'd15, 10'd1023);
        send_readout(TBL_LEN_HIST, 512);
        send_readout(TBL_POS_A, 512);

        // one overlong read of random bases
        random_read(520);
        send_readout(TBL_LEN_HIST, 512);
        send_readout(TBL_N_HIST, 512);

        // register settings, extremes included
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            quiesce();
            case (phase)
                0: begin write_reg(CFG_MAX_N_BASES, 0); write_reg(CFG_LOW_QUAL_FRAC, 0);
                         write_reg(CFG_QUALITY_OFFSET, 0); end
                1: begin write_reg(CFG_MAX_N_BASES, 511); write_reg(CFG_LOW_QUAL_FRAC, 256);
                         write_reg(CFG_QUALITY_OFFSET, 127); end
                2: begin write_reg(CFG_MAX_N_BASES, 9'h1ff); write_reg(CFG_LOW_QUAL_FRAC, 9'h1ff);
                         write_reg(CFG_QUALITY_OFFSET, 64); end
                3: begin write_reg(CFG_MAX_N_BASES, 9'($urandom_range(0, 6)));
                         write_reg(CFG_LOW_QUAL_FRAC, 9'($urandom_range(0, 256)));
                         write_reg(CFG_QUALITY_OFFSET, 9'($urandom_range(20, 70))); end
                default: begin write_reg(CFG_MAX_N_BASES, 3); write_reg(CFG_LOW_QUAL_FRAC, 128);
                         write_reg(CFG_QUALITY_OFFSET, 33); calm = 1; end
            endcase
            cfg_we <= 0;
            while (sent < (phase + 1) * 12)
            begin
                int len;
                if ($urandom_range(0, 3) == 0)
                begin
                    random_readout();
                    sent++;
                end
                else
                begin
                    len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
                    random_read(len);
                    sent += len;
                end
            end
        end

        in_ch.valid <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
